@@ design/fft_pkg.sv @@
// fft_pkg: shared constants, types, state codes and twiddle tables
// for the radix-2 FFT block. Depends on nothing.
`timescale 1ns / 1ps
package fft_pkg;

   localparam int MAX_POINTS = 1024;
   localparam int ADDR_W     = $clog2(MAX_POINTS);
   localparam int DATA_W     = 32;
   localparam int WORD_W     = 2 * DATA_W;
   localparam int TW_W       = 16;
   localparam int TW_FRAC    = TW_W - 1;
   localparam int TW_ENTRIES = MAX_POINTS / 2;
   localparam int TW_QUARTER = MAX_POINTS / 4;
   localparam int TW_AW      = ADDR_W - 1;
   localparam int TWX_W      = TW_W + 2;
   localparam int PROD_W     = DATA_W + TWX_W;
   localparam int V_W        = PROD_W - TW_FRAC;
   localparam int SUM_W      = V_W + 1;
   localparam int LOG_W      = 4;
   localparam int MIN_LOG    = 5;
   localparam int OP_W       = 2;
   localparam int SAMPLE_W   = 16;
   localparam int OUT_W      = 32;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_LOG_SIZE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERSE  = 1'b1;
   localparam logic [LOG_W-1:0]     LOG_RESET    = LOG_W'(ADDR_W);

   localparam real PI = 3.14159265359;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD = 2'd0,
      OP_RUN  = 2'd1,
      OP_READ = 2'd2
   } op_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_RSP,
      ST_BR_RDI, ST_BR_RDJ, ST_BR_WI, ST_BR_WJ,
      ST_BF_RDA, ST_BF_RDB, ST_BF_M0, ST_BF_M1, ST_BF_M2, ST_BF_M3, ST_BF_M4,
      ST_BF_WA, ST_BF_WB,
      ST_SC_RD, ST_SC_WR
   } state_type;

   typedef enum logic [2:0] {
      MS_IDLE, MS_CBR, MS_SBI, MS_CBI, MS_SBR, MS_VI
   } mul_step_type;

   typedef struct packed {
      logic         cap_a;
      logic         cap_tw;
      mul_step_type step;
   } bfly_ctrl_type;

   typedef logic signed [TW_W:0] tw_type;
   typedef tw_type tw_tab_type [TW_QUARTER];

   // Build a first-quarter-turn table of rounded twiddles at elaboration;
   // the second quarter is folded from it by the sequencer
   function automatic tw_tab_type build_tw(input bit want_sin);
      tw_tab_type t;
      real        ang;
      real        v;
      for (int k = 0; k < TW_QUARTER; k++) begin
         ang = 2.0 * PI * k / MAX_POINTS;
         v   = want_sin ? $sin(ang) : $cos(ang);
         t[k] = tw_type'($rtoi($floor(v * (2.0 ** TW_FRAC) + 0.5)));
      end
      return t;
   endfunction

   localparam tw_tab_type TW_COS = build_tw(1'b0);
   localparam tw_tab_type TW_SIN = build_tw(1'b1);

   localparam logic signed [SUM_W-1:0] SAT_HI =
      {{(SUM_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

   // Clamp a butterfly sum to the store width
   function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [SUM_W-1:0] x);
      if (x > SAT_HI) return SAT_HI[DATA_W-1:0];
      if (x < SAT_LO) return SAT_LO[DATA_W-1:0];
      return x[DATA_W-1:0];
   endfunction

endpackage

@@ design/radix2_complex_fft_top.sv @@
// Radix-2 FFT top: a load is written on acceptance, busy staying low; a read holds busy
// and gives its bin in the cycle after acceptance, and a new request is taken once it is out.
// Transform: a bit-reversal pass that swaps each reversed pair, (N/2)log2N butterflies of
// two reads, five multiply steps and two writes each, and for inverse a 1/N scaling pass.
// One shared multiplier, one store read port and one write port. The receiver cannot stall.
// Reset clears the sequencer and sets log_size 10, forward; the store is not cleared.
`timescale 1ns / 1ps
module radix2_complex_fft_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_start,
   input  logic [fft_pkg::OP_W-1:0]            req_operation,
   input  logic [fft_pkg::ADDR_W-1:0]          req_point_index,
   input  logic signed [fft_pkg::SAMPLE_W-1:0] req_sample_real,
   input  logic signed [fft_pkg::SAMPLE_W-1:0] req_sample_imag,
   output logic                                busy,
   output logic                                rsp_strobe,
   output logic signed [fft_pkg::OUT_W-1:0]    rsp_bin_real,
   output logic signed [fft_pkg::OUT_W-1:0]    rsp_bin_imag,
   output logic [fft_pkg::ADDR_W-1:0]          rsp_bin_position,
   input  logic                                csr_write,
   input  logic [fft_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [fft_pkg::CSR_DATA_W-1:0]      csr_data
);
   import fft_pkg::*;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [WORD_W-1:0] ram_wdata, ram_rdata, sum_word, diff_word;
   bfly_ctrl_type     bfly_ctrl;
   tw_type            tw_cos, tw_sin;
   logic              inverse;

   // Work store, imaginary over real
   fft_ram #(.WIDTH(WORD_W), .DEPTH(MAX_POINTS)) u_ram (
      .clock(clock), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
      .raddr(ram_raddr), .rdata(ram_rdata)
   );

   // Shared butterfly unit
   fft_bfly u_bfly (
      .clock(clock), .ctrl(bfly_ctrl), .rdata(ram_rdata), .tw_cos(tw_cos),
      .tw_sin(tw_sin), .inverse(inverse), .sum_word(sum_word), .diff_word(diff_word)
   );

   // Sequencer
   fft_seq u_seq (
      .clock(clock), .reset(reset), .req_start(req_start),
      .req_operation(req_operation), .req_point_index(req_point_index),
      .req_sample_real(req_sample_real), .req_sample_imag(req_sample_imag),
      .busy(busy), .rsp_strobe(rsp_strobe), .rsp_bin_real(rsp_bin_real),
      .rsp_bin_imag(rsp_bin_imag), .rsp_bin_position(rsp_bin_position),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .ram_we(ram_we), .ram_waddr(ram_waddr), .ram_wdata(ram_wdata),
      .ram_raddr(ram_raddr), .ram_rdata(ram_rdata), .bfly_ctrl(bfly_ctrl),
      .tw_cos(tw_cos), .tw_sin(tw_sin), .inverse(inverse),
      .sum_word(sum_word), .diff_word(diff_word)
   );
endmodule

@@ design/fft_ram.sv @@
// fft_ram: generic single-write, single-read RAM with registered read.
// Depends on nothing.
`timescale 1ns / 1ps
module fft_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

@@ design/fft_bfly.sv @@
// fft_bfly: butterfly datapath around one shared twiddle multiplier.
// Depends on fft_pkg; stepped by fft_seq through a bfly_ctrl_type.
`timescale 1ns / 1ps
module fft_bfly (
   input  logic                        clock,
   input  fft_pkg::bfly_ctrl_type      ctrl,
   input  logic [fft_pkg::WORD_W-1:0]  rdata,
   input  fft_pkg::tw_type             tw_cos,
   input  fft_pkg::tw_type             tw_sin,
   input  logic                        inverse,
   output logic [fft_pkg::WORD_W-1:0]  sum_word,
   output logic [fft_pkg::WORD_W-1:0]  diff_word
);
   import fft_pkg::*;

   localparam logic signed [PROD_W-1:0] RND = PROD_W'(1) <<< (TW_FRAC - 1);

   logic signed [DATA_W-1:0] a_re_ff, a_im_ff, b_re_ff, b_im_ff;
   logic signed [TWX_W-1:0]  c_ff, s_ff, s_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in, acc_ff, tmp;
   logic signed [V_W-1:0]    vr_ff, vi_ff;
   logic signed [TWX_W-1:0]  op_t;
   logic signed [DATA_W-1:0] op_d, rd_re, rd_im;
   logic signed [SUM_W-1:0]  sr, si, dr, di;

   assign rd_re = rdata[DATA_W-1:0];
   assign rd_im = rdata[WORD_W-1:DATA_W];
   // Conjugate the twiddle for the inverse
   assign s_in  = inverse ? -TWX_W'(tw_sin) : TWX_W'(tw_sin);

   // Pick the multiplier operands for this step
   always_comb begin
      case (ctrl.step)
         MS_CBR:  begin op_t = c_ff; op_d = rd_re;   end
         MS_SBI:  begin op_t = s_ff; op_d = b_im_ff; end
         MS_CBI:  begin op_t = c_ff; op_d = b_im_ff; end
         MS_SBR:  begin op_t = s_ff; op_d = b_re_ff; end
         default: begin op_t = '0;   op_d = '0;      end
      endcase
      prod_in = op_t * op_d;
      tmp = '0;
      if (ctrl.step == MS_CBI) tmp = acc_ff - prod_ff + RND;
      else if (ctrl.step == MS_VI) tmp = acc_ff + prod_ff + RND;
   end

   // Capture operands, run the multiply-accumulate sequence
   always_ff @(posedge clock) begin
      if (ctrl.cap_a) begin
         a_re_ff <= rd_re;
         a_im_ff <= rd_im;
      end
      if (ctrl.cap_tw) begin
         c_ff <= TWX_W'(tw_cos);
         s_ff <= s_in;
      end
      if (ctrl.step == MS_CBR) begin
         b_re_ff <= rd_re;
         b_im_ff <= rd_im;
      end
      prod_ff <= prod_in;
      if (ctrl.step == MS_SBI || ctrl.step == MS_SBR) acc_ff <= prod_ff;
      if (ctrl.step == MS_CBI) vr_ff <= tmp[PROD_W-1:TW_FRAC];
      if (ctrl.step == MS_VI)  vi_ff <= tmp[PROD_W-1:TW_FRAC];
   end

   // Sum and difference, saturated
   assign sr = SUM_W'(a_re_ff) + SUM_W'(vr_ff);
   assign si = SUM_W'(a_im_ff) + SUM_W'(vi_ff);
   assign dr = SUM_W'(a_re_ff) - SUM_W'(vr_ff);
   assign di = SUM_W'(a_im_ff) - SUM_W'(vi_ff);
   assign sum_word  = {sat_data(si), sat_data(sr)};
   assign diff_word = {sat_data(di), sat_data(dr)};
endmodule

@@ design/fft_seq.sv @@
// fft_seq: request decode, configuration registers and the pass sequencer
// (bit reversal, butterfly passes, inverse scaling). Depends on fft_pkg.
`timescale 1ns / 1ps
module fft_seq (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_start,
   input  logic [fft_pkg::OP_W-1:0]            req_operation,
   input  logic [fft_pkg::ADDR_W-1:0]          req_point_index,
   input  logic signed [fft_pkg::SAMPLE_W-1:0] req_sample_real,
   input  logic signed [fft_pkg::SAMPLE_W-1:0] req_sample_imag,
   output logic                                busy,
   output logic                                rsp_strobe,
   output logic signed [fft_pkg::OUT_W-1:0]    rsp_bin_real,
   output logic signed [fft_pkg::OUT_W-1:0]    rsp_bin_imag,
   output logic [fft_pkg::ADDR_W-1:0]          rsp_bin_position,
   input  logic                                csr_write,
   input  logic [fft_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [fft_pkg::CSR_DATA_W-1:0]      csr_data,
   output logic                                ram_we,
   output logic [fft_pkg::ADDR_W-1:0]          ram_waddr,
   output logic [fft_pkg::WORD_W-1:0]          ram_wdata,
   output logic [fft_pkg::ADDR_W-1:0]          ram_raddr,
   input  logic [fft_pkg::WORD_W-1:0]          ram_rdata,
   output fft_pkg::bfly_ctrl_type              bfly_ctrl,
   output fft_pkg::tw_type                     tw_cos,
   output fft_pkg::tw_type                     tw_sin,
   output logic                                inverse,
   input  logic [fft_pkg::WORD_W-1:0]          sum_word,
   input  logic [fft_pkg::WORD_W-1:0]          diff_word
);
   import fft_pkg::*;

   state_type              state_ff, state_in;
   logic [LOG_W-1:0]       log_size_ff;
   logic                   inverse_ff;
   logic [ADDR_W-1:0]      i_ff, i_in, pos_ff, pos_in;
   logic [TW_AW-1:0]       bf_ff, bf_in;
   logic [LOG_W-1:0]       stage_ff, stage_in;
   logic [WORD_W-1:0]      swap_ff, swap_in;
   logic [LOG_W-1:0]       lg;
   logic [ADDR_W-1:0]      n_mask, idx, rev_full, j_idx, k_idx, kh_idx;
   logic [TW_AW-1:0]       h_mask, tw_j, tw_idx;
   logic [TW_AW-2:0]       tw_sub;
   logic                   last_i, last_bf, last_stage;
   logic [WORD_W-1:0]      load_word, scale_word;

   // Clamp the length to the supported range
   always_comb begin
      if (log_size_ff < LOG_W'(MIN_LOG)) lg = LOG_W'(MIN_LOG);
      else if (log_size_ff > LOG_W'(ADDR_W)) lg = LOG_W'(ADDR_W);
      else lg = log_size_ff;
   end

   // Address generation
   always_comb begin
      for (int b = 0; b < ADDR_W; b++) rev_full[b] = i_ff[ADDR_W-1-b];
   end
   assign n_mask  = ~({ADDR_W{1'b1}} << lg);
   assign idx     = req_point_index & n_mask;
   assign j_idx   = rev_full >> (LOG_W'(ADDR_W) - lg);
   assign h_mask  = ~({TW_AW{1'b1}} << stage_ff);
   assign k_idx   = {bf_ff & ~h_mask, 1'b0} | {1'b0, bf_ff & h_mask};
   assign kh_idx  = k_idx | (ADDR_W'(1) << stage_ff);
   assign tw_j    = bf_ff & h_mask;
   assign tw_idx  = tw_j << (LOG_W'(TW_AW) - stage_ff);
   // Fold the second quarter turn onto the first: W(k + N/4) = j * W(k)
   assign tw_sub  = tw_idx[TW_AW-2:0];
   assign tw_cos  = tw_idx[TW_AW-1] ? -TW_SIN[tw_sub] : TW_COS[tw_sub];
   assign tw_sin  = tw_idx[TW_AW-1] ? TW_COS[tw_sub] : TW_SIN[tw_sub];
   assign last_i     = (i_ff == n_mask);
   assign last_bf    = (bf_ff == n_mask[ADDR_W-1:1]);
   assign last_stage = (stage_ff == lg - LOG_W'(1));
   assign inverse    = inverse_ff;

   assign load_word  = {DATA_W'(req_sample_imag), DATA_W'(req_sample_real)};
   assign scale_word = {DATA_W'($signed(ram_rdata[WORD_W-1:DATA_W]) >>> lg),
                        DATA_W'($signed(ram_rdata[DATA_W-1:0]) >>> lg)};

   assign rsp_bin_real     = OUT_W'($signed(ram_rdata[DATA_W-1:0]));
   assign rsp_bin_imag     = OUT_W'($signed(ram_rdata[WORD_W-1:DATA_W]));
   assign rsp_bin_position = pos_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         log_size_ff <= LOG_RESET;
         inverse_ff  <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_LOG_SIZE: log_size_ff <= csr_data[LOG_W-1:0];
            CSR_INVERSE:  inverse_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   // State and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      i_ff     <= i_in;
      bf_ff    <= bf_in;
      stage_ff <= stage_in;
      swap_ff  <= swap_in;
      pos_ff   <= pos_in;
   end

   // Next state and store access
   always_comb begin
      state_in   = state_ff;
      i_in       = i_ff;
      bf_in      = bf_ff;
      stage_in   = stage_ff;
      swap_in    = swap_ff;
      pos_in     = pos_ff;
      ram_we     = 1'b0;
      ram_waddr  = i_ff;
      ram_wdata  = ram_rdata;
      ram_raddr  = i_ff;
      bfly_ctrl  = '{cap_a: 1'b0, cap_tw: 1'b0, step: MS_IDLE};
      rsp_strobe = 1'b0;
      busy       = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_start) begin
               case (op_type'(req_operation))
                  OP_LOAD: begin
                     ram_we    = 1'b1;
                     ram_waddr = idx;
                     ram_wdata = load_word;
                  end
                  OP_RUN: begin
                     i_in     = '0;
                     state_in = ST_BR_RDI;
                  end
                  OP_READ: begin
                     ram_raddr = idx;
                     pos_in    = idx;
                     state_in  = ST_RSP;
                  end
                  default: ;
               endcase
            end
         end
         ST_RSP: begin
            rsp_strobe = 1'b1;
            state_in   = ST_IDLE;
         end
         // Bit-reversal swaps
         ST_BR_RDI: begin
            if (j_idx > i_ff) begin
               state_in = ST_BR_RDJ;
            end else if (last_i) begin
               bf_in    = '0;
               stage_in = '0;
               state_in = ST_BF_RDA;
            end else begin
               i_in = i_ff + ADDR_W'(1);
            end
         end
         ST_BR_RDJ: begin
            ram_raddr = j_idx;
            swap_in   = ram_rdata;
            state_in  = ST_BR_WI;
         end
         ST_BR_WI: begin
            ram_we    = 1'b1;
            ram_waddr = i_ff;
            ram_wdata = ram_rdata;
            state_in  = ST_BR_WJ;
         end
         ST_BR_WJ: begin
            ram_we    = 1'b1;
            ram_waddr = j_idx;
            ram_wdata = swap_ff;
            if (last_i) begin
               bf_in    = '0;
               stage_in = '0;
               state_in = ST_BF_RDA;
            end else begin
               i_in     = i_ff + ADDR_W'(1);
               state_in = ST_BR_RDI;
            end
         end
         // Butterflies
         ST_BF_RDA: begin
            ram_raddr = k_idx;
            state_in  = ST_BF_RDB;
         end
         ST_BF_RDB: begin
            ram_raddr = kh_idx;
            bfly_ctrl = '{cap_a: 1'b1, cap_tw: 1'b1, step: MS_IDLE};
            state_in  = ST_BF_M0;
         end
         ST_BF_M0: begin
            bfly_ctrl.step = MS_CBR;
            state_in = ST_BF_M1;
         end
         ST_BF_M1: begin
            bfly_ctrl.step = MS_SBI;
            state_in = ST_BF_M2;
         end
         ST_BF_M2: begin
            bfly_ctrl.step = MS_CBI;
            state_in = ST_BF_M3;
         end
         ST_BF_M3: begin
            bfly_ctrl.step = MS_SBR;
            state_in = ST_BF_M4;
         end
         ST_BF_M4: begin
            bfly_ctrl.step = MS_VI;
            state_in = ST_BF_WA;
         end
         ST_BF_WA: begin
            ram_we    = 1'b1;
            ram_waddr = k_idx;
            ram_wdata = sum_word;
            state_in  = ST_BF_WB;
         end
         ST_BF_WB: begin
            ram_we    = 1'b1;
            ram_waddr = kh_idx;
            ram_wdata = diff_word;
            if (last_bf) begin
               bf_in = '0;
               if (last_stage) begin
                  i_in     = '0;
                  state_in = inverse_ff ? ST_SC_RD : ST_IDLE;
               end else begin
                  stage_in = stage_ff + LOG_W'(1);
                  state_in = ST_BF_RDA;
               end
            end else begin
               bf_in    = bf_ff + TW_AW'(1);
               state_in = ST_BF_RDA;
            end
         end
         // Inverse scaling by 1/N
         ST_SC_RD: begin
            state_in = ST_SC_WR;
         end
         ST_SC_WR: begin
            ram_we    = 1'b1;
            ram_waddr = i_ff;
            ram_wdata = scale_word;
            if (last_i) begin
               state_in = ST_IDLE;
            end else begin
               i_in     = i_ff + ADDR_W'(1);
               state_in = ST_SC_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule
